/* hw/rtl/upq_pkg.sv */
// Shared constants and types for the unsorted priority queue.
// Used by upq_cmp and unsorted_priority_queue; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package upq_pkg;

	localparam int DEPTH = 16;
	localparam int DW    = 32;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_ENQ = 2'd0;
	localparam logic [1:0] OP_DEQ = 2'd1;
	localparam logic [1:0] OP_REM = 2'd2;
	localparam logic [1:0] OP_UPD = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic gt;
		logic eq;
	} cmp_t;

endpackage
`default_nettype wire

/* hw/rtl/upq_cmp.sv */
// Shared signed comparator used by every scan of the entry store.
// Depends on upq_pkg for the data width and the result struct.
`timescale 1ns / 1ps
`default_nettype none
module upq_cmp (
	input  wire logic signed [upq_pkg::DW-1:0] a,
	input  wire logic signed [upq_pkg::DW-1:0] b,
	output upq_pkg::cmp_t                      res
);

	always_comb begin
		res.gt = (a > b);
		res.eq = (a == b);
	end

endmodule
`default_nettype wire

/* hw/rtl/unsorted_priority_queue.sv */
// Unsorted priority queue top level: entry store, scan/compact sequencer, result register.
// Depends on upq_pkg and on upq_cmp, the one comparator shared by all scans.
`timescale 1ns / 1ps
`default_nettype none

// The queue holds up to 16 signed 32-bit entries in insertion order in a small
// single-write, single-read memory with a registered read port. An enqueue goes
// from the finish state into the output register, and in_ready returns in the
// same cycle that its result becomes valid. Dequeue-max, remove and update walk
// the store from the newest entry to the oldest through one shared signed
// comparator, one entry per cycle. Dequeue-max and remove then close the gap by
// copying each later entry down one place, again one entry per cycle through the
// memory port. The finish state then hands the result to the output register,
// once that register is free. Taking the oldest entry of a full store is the
// worst case, and the next item can be taken as soon as this result is valid.
// The block works on one item at a time: in_ready is high only while the
// sequencer is idle, but a finished result may wait in the output register
// while the next item is already accepted.
module unsorted_priority_queue (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       op,
	input  wire logic signed [upq_pkg::DW-1:0]    value,
	input  wire logic signed [upq_pkg::DW-1:0]    replacement,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [upq_pkg::DW-1:0]         result_value,
	output logic [1:0]                            status,
	output logic [upq_pkg::CW-1:0]                entry_count
);

	localparam int AW = upq_pkg::AW;
	localparam int CW = upq_pkg::CW;
	localparam int DW = upq_pkg::DW;

	// Sequencer states.
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]    state_q;
	logic [1:0]    op_q;
	logic [DW-1:0] key_q;
	logic [DW-1:0] nval_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] iss_q;
	logic [CW-1:0] sh_q;
	logic          found_q;
	logic [AW-1:0] pos_q;
	logic [DW-1:0] best_q;
	logic [DW-1:0] res_q;
	logic [1:0]    st_q;

	// Scan pipeline: the entry read last cycle and its index.
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	// Compaction pipeline: a pending write of the entry read last cycle.
	logic          wv_s1;
	logic [AW-1:0] wa_s1;

	logic          out_valid_q;
	logic [DW-1:0] out_value_q;
	logic [1:0]    out_status_q;
	logic [CW-1:0] out_count_q;

	// Entry store.
	logic [DW-1:0] mem [upq_pkg::DEPTH];
	logic [DW-1:0] rdata_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data;

	logic          accept;
	logic          full;
	logic [CW-1:0] iss_m1;
	logic          scan_done;
	logic          sh_rd;
	logic          out_free;
	logic [CW-1:0] sh_start;
	logic [CW-1:0] sh_m1;

	upq_pkg::cmp_t cmp_res;
	logic [DW-1:0] cmp_b;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q >= CW'(upq_pkg::DEPTH));
	assign iss_m1    = iss_q - CW'(1);
	assign scan_done = (state_q == S_SCAN) && (iss_q == '0) && !vld_s1;
	assign sh_rd     = (state_q == S_SHIFT) && (sh_q < count_q);
	assign out_free  = !out_valid_q || out_ready;
	assign sh_start  = CW'(pos_q) + CW'(1);
	assign sh_m1     = sh_q - CW'(1);

	// Dequeue compares against the best entry so far; remove and update against the key.
	assign cmp_b = (op_q == upq_pkg::OP_DEQ) ? best_q : key_q;

	upq_cmp u_cmp (
		.a   (rdata_q),
		.b   (cmp_b),
		.res (cmp_res)
	);

	// Memory port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = iss_m1[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = value;
		case (state_q)
			S_IDLE: begin
				if (accept && (op == upq_pkg::OP_ENQ) && !full) begin
					wr_en = 1'b1;
				end
			end
			S_SCAN: begin
				rd_en   = (iss_q != '0);
				rd_addr = iss_m1[AW-1:0];
				if (scan_done && found_q && (op_q == upq_pkg::OP_UPD)) begin
					wr_en   = 1'b1;
					wr_addr = pos_q;
					wr_data = nval_q;
				end
			end
			S_SHIFT: begin
				rd_en   = sh_rd;
				rd_addr = sh_q[AW-1:0];
				wr_en   = wv_s1;
				wr_addr = wa_s1;
				wr_data = rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op;
			key_q  <= value;
			nval_q <= replacement;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= iss_m1[AW-1:0];
		end
		if (state_q == S_SHIFT) begin
			wa_s1 <= sh_m1[AW-1:0];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			iss_q   <= '0;
			sh_q    <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
			best_q  <= '0;
			res_q   <= '0;
			st_q    <= upq_pkg::ST_OK;
			vld_s1  <= 1'b0;
			wv_s1   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						iss_q   <= count_q;
						found_q <= 1'b0;
						vld_s1  <= 1'b0;
						wv_s1   <= 1'b0;
						res_q   <= '0;
						if (op == upq_pkg::OP_ENQ) begin
							if (full) begin
								st_q <= upq_pkg::ST_FULL;
							end else begin
								st_q    <= upq_pkg::ST_OK;
								count_q <= count_q + CW'(1);
							end
							state_q <= S_FIN;
						end else if (count_q == '0) begin
							st_q    <= (op == upq_pkg::OP_DEQ) ? upq_pkg::ST_EMPTY
							                                   : upq_pkg::ST_NOTFOUND;
							state_q <= S_FIN;
						end else begin
							st_q    <= upq_pkg::ST_OK;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						iss_q <= iss_m1;
					end
					// The scan runs newest first, so the first hit is the newest
					// match, and a strict compare keeps the newer of equal maxima.
					if (vld_s1) begin
						if (op_q == upq_pkg::OP_DEQ) begin
							if (!found_q || cmp_res.gt) begin
								found_q <= 1'b1;
								best_q  <= rdata_q;
								pos_q   <= idx_s1;
							end
						end else if (!found_q && cmp_res.eq) begin
							found_q <= 1'b1;
							pos_q   <= idx_s1;
						end
					end
					if (scan_done) begin
						wv_s1 <= 1'b0;
						sh_q  <= sh_start;
						if (!found_q) begin
							st_q    <= upq_pkg::ST_NOTFOUND;
							state_q <= S_FIN;
						end else if (op_q == upq_pkg::OP_UPD) begin
							state_q <= S_FIN;
						end else begin
							if (op_q == upq_pkg::OP_DEQ) begin
								res_q <= best_q;
							end
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					wv_s1 <= sh_rd;
					if (sh_rd) begin
						sh_q <= sh_q + CW'(1);
					end
					if (!sh_rd && !wv_s1) begin
						count_q <= count_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: a result may sit here while the next item is worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && out_free) begin
			out_value_q  <= res_q;
			out_status_q <= st_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_status_q;
	assign entry_count  = out_count_q;

	// The store never holds more entries than it has room for.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(upq_pkg::DEPTH))
		else $error("entry count exceeds the store depth");

	// A full status is only reported when the store is at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == upq_pkg::ST_FULL)) |->
		(out_count_q == CW'(upq_pkg::DEPTH)))
		else $error("full status with a store below capacity");

	// An empty status goes with an empty store and a zero value.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == upq_pkg::ST_EMPTY)) |->
		((out_count_q == '0) && (out_value_q == '0)))
		else $error("empty status with entries or a value");

	// The sequencer is busy in the cycle after an item is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("item accepted on two consecutive cycles");

endmodule
`default_nettype wire
